// ===== rtl/sfrp_pkg.sv =====
package sfrp_pkg;

	localparam int unsigned WordW = 36;
	localparam int unsigned KindW = 3;

	typedef logic [WordW-1:0] word_t;
	typedef logic [KindW-1:0] kind_t;

	localparam kind_t KIND_HALF  = 3'd0;
	localparam kind_t KIND_FULL  = 3'd1;
	localparam kind_t KIND_EXT   = 3'd2;
	localparam kind_t KIND_RELOC = 3'd3;
	localparam kind_t KIND_POL   = 3'd4;

	typedef struct packed {
		word_t symbol_name;
		kind_t record_kind;
		word_t symbol_value;
		word_t reloc_name;
		logic  commented;
	} record_t;

	typedef struct packed {
		logic    fire;
		record_t rec;
	} result_t;

endpackage

// ===== rtl/sfrp_word_if.sv =====
interface sfrp_word_if
	import sfrp_pkg::*;
	();
	logic  valid;
	logic  ready;
	word_t word;

	modport source (output valid, output word, input ready);
	modport sink (input valid, input word, output ready);
endinterface

// ===== rtl/sfrp_record_if.sv =====
interface sfrp_record_if
	import sfrp_pkg::*;
	();
	logic  valid;
	logic  ready;
	word_t symbol_name;
	kind_t record_kind;
	word_t symbol_value;
	word_t reloc_name;
	logic  commented;

	modport source (output valid, output symbol_name, output record_kind,
		output symbol_value, output reloc_name, output commented, input ready);
	modport sink (input valid, input symbol_name, input record_kind,
		input symbol_value, input reloc_name, input commented, output ready);
endinterface

// ===== rtl/sfrp_core.sv =====
module sfrp_core
	import sfrp_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    step,
	input  word_t   word,
	output result_t res
);

	localparam word_t F_TAG    = 36'o200000000000;
	localparam word_t F_MAC    = 36'o020000000000;
	localparam word_t F_PNT    = 36'o004000000000;
	localparam word_t F_UND    = 36'o002000000000;
	localparam word_t F_EXT    = 36'o001000000000;
	localparam word_t F_ENT    = 36'o000200000000;
	localparam word_t F_MDF    = 36'o000020000000;
	localparam word_t F_SPT    = 36'o000010000000;
	localparam word_t F_LEL    = 36'o000002000000;
	localparam word_t F_REL    = 36'o000001000000;
	localparam word_t M_LEFT   = 36'o777777000000;
	localparam word_t M_TOP6   = 36'o770000000000;
	localparam word_t TBL_MARK = 36'o166371556441;
	localparam word_t END_MARK = 36'o373737373737;
	localparam word_t OP_LIMIT = 36'd14;
	localparam word_t COM_MASK = F_TAG | F_UND | F_EXT | F_ENT | F_MDF | F_SPT | F_LEL | F_REL;

	localparam int unsigned CntW = 21;

	typedef enum logic [14:0] {
		PH_HDR     = 15'b000000000000001,
		PH_START   = 15'b000000000000010,
		PH_FLAGS   = 15'b000000000000100,
		PH_MLINK   = 15'b000000000001000,
		PH_MBODY   = 15'b000000000010000,
		PH_MTAIL   = 15'b000000000100000,
		PH_ARGS    = 15'b000000001000000,
		PH_PTR     = 15'b000000010000000,
		PH_EXTNAME = 15'b000000100000000,
		PH_SPKIND  = 15'b000001000000000,
		PH_RSKIP   = 15'b000010000000000,
		PH_RNAME   = 15'b000100000000000,
		PH_PLINK   = 15'b001000000000000,
		PH_POP     = 15'b010000000000000,
		PH_POLSKIP = 15'b100000000000000
	} phase_t;

	phase_t           phase_q, phase_n;
	logic [CntW-1:0]  cnt_q, cnt_n, cnt_dec;
	word_t            sym_q, sym_n;
	word_t            flags_q, flags_n;
	word_t            value_q, value_n;
	logic             more_q, more_n;
	logic             finished_q, finished_n;
	logic [CntW-1:0]  arg_words;

	// Blocks of five words: (count + 1) * 5
	assign arg_words = ({3'b000, word[35:18]} + 21'd1)
		+ (({3'b000, word[35:18]} + 21'd1) << 2);
	assign cnt_dec = (cnt_q != '0) ? cnt_q - 21'd1 : cnt_q;

	always_comb begin
		phase_n    = phase_q;
		cnt_n      = cnt_q;
		sym_n      = sym_q;
		flags_n    = flags_q;
		value_n    = value_q;
		more_n     = more_q;
		finished_n = finished_q;
		res.fire   = 1'b0;
		res.rec.symbol_name  = sym_q;
		res.rec.record_kind  = KIND_HALF;
		res.rec.symbol_value = word;
		res.rec.reloc_name   = '0;
		res.rec.commented    = ((flags_q & COM_MASK) != '0) || (sym_q == TBL_MARK);
		if (!finished_q) begin
			case (phase_q)
				PH_HDR, PH_ARGS: begin
					cnt_n = cnt_dec;
					if (cnt_dec == '0)
						phase_n = PH_START;
				end
				PH_FLAGS: begin
					flags_n = word;
					res.rec.commented = ((word & COM_MASK) != '0) || (sym_q == TBL_MARK);
					if ((word & F_MAC) != '0) begin
						phase_n = PH_MLINK;
					end else if ((word & (F_PNT | F_SPT)) == '0) begin
						phase_n  = PH_START;
						res.fire = 1'b1;
						res.rec.symbol_value = {18'd0, word[17:0]};
					end else begin
						phase_n = PH_PTR;
					end
				end
				PH_MLINK: begin
					more_n  = (word & M_LEFT) != '0;
					cnt_n   = 21'd3;
					phase_n = PH_MBODY;
				end
				PH_MBODY: begin
					cnt_n = cnt_dec;
					if (cnt_dec == '0)
						phase_n = more_q ? PH_MLINK : PH_MTAIL;
				end
				PH_MTAIL: begin
					if ((word & M_TOP6) != '0) begin
						if (word == END_MARK) begin
							finished_n = 1'b1;
						end else begin
							sym_n   = word;
							phase_n = PH_FLAGS;
						end
					end else begin
						cnt_n   = arg_words;
						phase_n = PH_ARGS;
					end
				end
				PH_PTR: begin
					if ((flags_q & F_EXT) != '0) begin
						phase_n = PH_EXTNAME;
					end else begin
						value_n = word;
						if ((flags_q & F_SPT) != '0) begin
							phase_n = PH_SPKIND;
						end else begin
							phase_n  = PH_START;
							res.fire = 1'b1;
							res.rec.record_kind = KIND_FULL;
						end
					end
				end
				PH_EXTNAME: begin
					phase_n  = PH_START;
					res.fire = 1'b1;
					res.rec.record_kind = KIND_EXT;
				end
				PH_SPKIND: begin
					if (word[35]) begin
						phase_n  = PH_PLINK;
						res.fire = 1'b1;
						res.rec.record_kind  = KIND_POL;
						res.rec.symbol_value = value_q;
					end else begin
						phase_n = PH_RSKIP;
					end
				end
				PH_RSKIP: phase_n = PH_RNAME;
				PH_RNAME: begin
					phase_n  = PH_START;
					res.fire = 1'b1;
					res.rec.record_kind  = KIND_RELOC;
					res.rec.symbol_value = value_q;
					res.rec.reloc_name   = word;
				end
				PH_PLINK: begin
					if (word == '0)
						phase_n = PH_POP;
				end
				PH_POP: begin
					if (word[35] || word >= OP_LIMIT) begin
						phase_n = PH_START;
					end else begin
						cnt_n   = 21'd6;
						phase_n = PH_POLSKIP;
					end
				end
				PH_POLSKIP: begin
					cnt_n = cnt_dec;
					if (cnt_dec == '0)
						phase_n = PH_PLINK;
				end
				default: begin
					// waiting for a symbol: drop zero words
					phase_n = PH_START;
					if (word != '0) begin
						if (word == END_MARK) begin
							finished_n = 1'b1;
						end else begin
							sym_n   = word;
							phase_n = PH_FLAGS;
						end
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HDR;
			cnt_q      <= 21'd5;
			sym_q      <= '0;
			flags_q    <= '0;
			value_q    <= '0;
			more_q     <= 1'b0;
			finished_q <= 1'b0;
		end else if (step) begin
			phase_q    <= phase_n;
			cnt_q      <= cnt_n;
			sym_q      <= sym_n;
			flags_q    <= flags_n;
			value_q    <= value_n;
			more_q     <= more_n;
			finished_q <= finished_n;
		end
	end

`ifndef ASSERT_OFF
	a_finished_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		finished_q |=> finished_q)
		else $error("end marker state cleared");
	a_no_record_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		finished_q |-> !res.fire)
		else $error("record produced after end marker");
	a_counter_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_MBODY || phase_q == PH_POLSKIP) |-> cnt_q != '0)
		else $error("skip counter empty in a counted phase");
`endif

endmodule

// ===== rtl/symbol_file_record_parser.sv =====
// Symbol-table record parser.
// Channel words (sfrp_word_if, sink): one 36-bit file word per item.
// Channel records (sfrp_record_if, source): one record per plain symbol
// definition: name, kind, value, relocation name and the commented flag.
// Both channels move an item at a rising edge with valid and ready high.
// The word that completes a record passes the input register, then the
// single decode step, then the record register. Throughput: one word per
// cycle while records does not stall.
// Words that produce no record are consumed without output.
// Reset (arst_n low) returns the parser to header skipping with five words
// to drop and clears the valid flags of both registers; the block is ready straight after.
// When records stalls, the held record stays and one further word waits in
// the input register; words then stall until the record is taken.
// After the end marker every further word is accepted and dropped.
module symbol_file_record_parser
	import sfrp_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	sfrp_word_if.sink     words,
	sfrp_record_if.source records
);

	logic    valid_s1;
	word_t   word_s1;
	logic    advance;
	logic    out_valid_q;
	record_t rec_q;
	result_t res;

	assign advance     = !out_valid_q || records.ready;
	assign words.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (words.ready) begin
			valid_s1 <= words.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (words.ready && words.valid)
			word_s1 <= words.word;
	end

	sfrp_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (valid_s1 && advance),
		.word   (word_s1),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && res.fire;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && res.fire)
			rec_q <= res.rec;
	end

	assign records.valid        = out_valid_q;
	assign records.symbol_name  = rec_q.symbol_name;
	assign records.record_kind  = rec_q.record_kind;
	assign records.symbol_value = rec_q.symbol_value;
	assign records.reloc_name   = rec_q.reloc_name;
	assign records.commented    = rec_q.commented;

`ifndef ASSERT_OFF
	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> rec_q.record_kind <= KIND_POL)
		else $error("record kind out of range");
	a_reloc_only_relocated: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && rec_q.record_kind != KIND_RELOC) |-> rec_q.reloc_name == '0)
		else $error("relocation name on a non-relocated record");
	a_half_value: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && rec_q.record_kind == KIND_HALF) |-> rec_q.symbol_value[35:18] == '0)
		else $error("half-word record carries a left half");
	a_stage_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(word_s1)))
		else $error("input register lost a waiting word");
`endif

endmodule
